// ===== src/canaf_pkg.sv =====
// Package for the CAN acceptance filter bank.
// Holds sizes, register codes and the command and status types used by the controller, datapath and top level.
// No dependencies.
package canaf_pkg;

    localparam int MAX_ENTRIES  = 32;
    localparam int IDX_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int ACTIVE_W     = 6;
    localparam int EFF_W        = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
    localparam int ID_W         = 11;
    localparam int WORD_W       = 16;
    localparam int MIDX_W       = 5;
    localparam int ENTRY_W      = 2 * ID_W + 1;
    localparam int ID_LSB       = 2;
    localparam int RTR_POS      = 1;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(32);

    localparam logic [PADDR_W-3:0] REG_ACTIVE_ENTRIES = '0;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_ILL_ARG = 1'b1;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
    } dp_stat_t;

endpackage

// ===== src/canaf_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the filter entry store; no dependencies.
module canaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/canaf_ctrl.sv =====
// Controller state machine of the CAN acceptance filter bank.
// Sequences accept, entry scan and result delivery; depends on canaf_pkg.
module canaf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                func,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  canaf_pkg::dp_stat_t stat,
    output canaf_pkg::dp_cmd_t  cmd
);

    import canaf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (func == FUNC_LOOKUP) ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/canaf_dp.sv =====
// Datapath of the CAN acceptance filter bank: entry RAM, valid bits, scan counter,
// match compare and result registers. Depends on canaf_pkg and canaf_ram.
module canaf_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  canaf_pkg::dp_cmd_t                  cmd,
    output canaf_pkg::dp_stat_t                 stat,
    input  logic [canaf_pkg::ACTIVE_W-1:0]      active_entries,
    input  logic                                func,
    input  logic [4:0]                          entry_index,
    input  logic [canaf_pkg::ID_W-1:0]          filter_id,
    input  logic [canaf_pkg::ID_W-1:0]          filter_mask,
    input  logic                                rtr_flag,
    input  logic [canaf_pkg::WORD_W-1:0]        received_word,
    output logic                                status,
    output logic                                matched,
    output logic [canaf_pkg::MIDX_W-1:0]        match_index,
    output logic                                dispatch
);

    import canaf_pkg::*;

    logic [EFF_W-1:0]       eff_count;
    logic [EFF_W-1:0]       active_ext;
    logic                   write_ok;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   issue;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [ID_W-1:0]        rd_id;
    logic [ID_W-1:0]        rd_mask;
    logic                   rd_rtr;
    logic                   hit_raw;
    logic                   hit;

    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [EFF_W-1:0]       addr_reg, addr_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic                   vrd_reg;
    logic [WORD_W-1:0]      word_reg;
    logic                   status_reg;
    logic                   matched_reg;
    logic [MIDX_W-1:0]      midx_reg;
    logic                   dispatch_reg;
    logic                   status_out_reg;
    logic                   matched_out_reg;
    logic [MIDX_W-1:0]      midx_out_reg;
    logic                   dispatch_out_reg;

    assign active_ext = EFF_W'(active_entries);
    assign eff_count  = (active_ext > EFF_W'(MAX_ENTRIES)) ? EFF_W'(MAX_ENTRIES) : active_ext;
    assign write_ok   = (EFF_W'(entry_index) < eff_count);
    assign ram_we     = cmd.accept && (func == FUNC_WRITE) && write_ok;
    assign ram_waddr  = IDX_W'(entry_index);
    assign ram_wdata  = {filter_id, rtr_flag, filter_mask};
    assign issue      = cmd.scan_step && (addr_reg < eff_count);

    canaf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (addr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_id   = ram_rdata[ENTRY_W-1 -: ID_W];
    assign rd_rtr  = ram_rdata[ID_W];
    assign rd_mask = ram_rdata[ID_W-1:0];

    // An entry never written is treated as ident 0 with mask all ones, so only a zero word matches it.
    always_comb
    begin
        if (vrd_reg)
        begin
            hit_raw = (((word_reg[ID_LSB +: ID_W] ^ rd_id) & rd_mask) == '0)
                      && (word_reg[RTR_POS] == rd_rtr);
        end
        else
        begin
            hit_raw = (word_reg == '0);
        end
    end

    assign hit            = pend_reg && hit_raw;
    assign stat.scan_done = hit || (!issue && !pend_reg);

    always_comb
    begin
        valid_next = valid_reg;
        addr_next  = addr_reg;
        pend_next  = pend_reg;
        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
        if (cmd.accept)
        begin
            addr_next = '0;
            pend_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            addr_next = issue ? (addr_reg + EFF_W'(1)) : addr_reg;
            pend_next = issue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            addr_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            addr_reg  <= addr_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cmp_idx_reg <= addr_reg[IDX_W-1:0];
            vrd_reg     <= valid_reg[addr_reg[IDX_W-1:0]];
        end
        if (cmd.accept)
        begin
            word_reg     <= received_word;
            status_reg   <= ((func == FUNC_WRITE) && !write_ok) ? STATUS_ILL_ARG : STATUS_OK;
            matched_reg  <= 1'b0;
            midx_reg     <= '0;
            dispatch_reg <= 1'b0;
        end
        else if (cmd.scan_step && hit)
        begin
            matched_reg  <= 1'b1;
            midx_reg     <= MIDX_W'(cmp_idx_reg);
            dispatch_reg <= vrd_reg;
        end
        if (cmd.load_out)
        begin
            status_out_reg   <= status_reg;
            matched_out_reg  <= matched_reg;
            midx_out_reg     <= midx_reg;
            dispatch_out_reg <= dispatch_reg;
        end
    end

    assign status      = status_out_reg;
    assign matched     = matched_out_reg;
    assign match_index = midx_out_reg;
    assign dispatch    = dispatch_out_reg;

endmodule

// ===== src/can_rx_acceptance_filter_bank_top.sv =====
// Top level of the CAN receive acceptance filter bank; depends on canaf_pkg, canaf_ctrl, canaf_dp.
// A write item goes from acceptance straight to the result state; a lookup item first scans up to
// N = min(active_entries, 32) entries through the one read port of the entry RAM,
// one entry per cycle, and stops at the first match. One item is in work at a time:
// the next can be accepted in the cycle after the result is loaded, even while it still waits.
// Reset clears all valid bits and sets active_entries to 32; no clearing pass is needed.
module can_rx_acceptance_filter_bank_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [canaf_pkg::PADDR_W-1:0]     paddr,
    input  logic [canaf_pkg::PDATA_W-1:0]     pwdata,
    output logic [canaf_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic [4:0]                        entry_index,
    input  logic [canaf_pkg::ID_W-1:0]        filter_id,
    input  logic [canaf_pkg::ID_W-1:0]        filter_mask,
    input  logic                              rtr_flag,
    input  logic [canaf_pkg::WORD_W-1:0]      received_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              status,
    output logic                              matched,
    output logic [canaf_pkg::MIDX_W-1:0]      match_index,
    output logic                              dispatch
);

    import canaf_pkg::*;

    dp_cmd_t               cmd;
    dp_stat_t              stat;
    logic [ACTIVE_W-1:0]   active_reg, active_next;
    logic                   reg_wr;
    logic                   sel_active;

    assign pready     = 1'b1;
    assign sel_active = (paddr[PADDR_W-1:2] == REG_ACTIVE_ENTRIES);
    assign reg_wr     = psel && penable && pwrite && pready;
    assign active_next = (reg_wr && sel_active) ? pwdata[ACTIVE_W-1:0] : active_reg;
    assign prdata     = sel_active ? PDATA_W'(active_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    canaf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .func      (func),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    canaf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .active_entries (active_reg),
        .func           (func),
        .entry_index    (entry_index),
        .filter_id      (filter_id),
        .filter_mask    (filter_mask),
        .rtr_flag       (rtr_flag),
        .received_word  (received_word),
        .status         (status),
        .matched        (matched),
        .match_index    (match_index),
        .dispatch       (dispatch)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after an item was accepted");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("result load did not raise out_valid");

    a_scan_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (in_stall && !cmd.accept))
        else $error("scan step while the input side is open");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !cmd.load_out)
        else $error("pending result overwritten");

endmodule

// ===== dv/tb_can_rx_acceptance_filter_bank_top.sv =====
// Testbench for the CAN receive acceptance filter bank top level.
// Filter writes and identifier lookups are checked against a scoreboard that tracks the bank.
// Depends on canaf_pkg and can_rx_acceptance_filter_bank_top.
`timescale 1ns / 1ps

module tb_can_rx_acceptance_filter_bank_top;

    import canaf_pkg::*;

    localparam logic [PADDR_W-1:0] ACTIVE_ENTRIES_ADDR = {REG_ACTIVE_ENTRIES, 2'b00};

    typedef struct {
        logic              func;
        logic [4:0]        entry_index;
        logic [ID_W-1:0]   filter_id;
        logic [ID_W-1:0]   filter_mask;
        logic              rtr_flag;
        logic [WORD_W-1:0] received_word;
    } filter_req_t;

    typedef struct {
        logic              status;
        logic              matched;
        logic [MIDX_W-1:0] match_index;
        logic              dispatch;
    } filter_verdict_t;

    class filter_bank_scoreboard;
        logic [WORD_W-1:0] entry_ident [MAX_ENTRIES];
        logic [WORD_W-1:0] entry_mask [MAX_ENTRIES];
        bit                entry_valid [MAX_ENTRIES];
        int unsigned       active_entries;
        filter_verdict_t   pending_verdicts [$];
        int unsigned       mismatches;

        function new();
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                entry_ident[i] = '0;
                entry_mask[i]  = '1;
                entry_valid[i] = 1'b0;
            end
            active_entries = ACTIVE_RESET;
            mismatches     = 0;
        endfunction

        function void set_active_entries(int unsigned value);
            active_entries = value;
        endfunction

        function int unsigned effective_count();
            return (active_entries < MAX_ENTRIES) ? active_entries : MAX_ENTRIES;
        endfunction

        function filter_verdict_t predict_verdict(filter_req_t r);
            filter_verdict_t v;
            int unsigned     count;
            bit              found;
            v     = '{STATUS_OK, 1'b0, '0, 1'b0};
            count = effective_count();
            found = 1'b0;
            if (r.func == FUNC_WRITE)
            begin
                if (r.entry_index < count)
                begin
                    entry_ident[r.entry_index] = {3'b000, r.filter_id, r.rtr_flag, 1'b0};
                    entry_mask[r.entry_index]  = {3'b000, r.filter_mask, 2'b10};
                    entry_valid[r.entry_index] = 1'b1;
                end
                else
                begin
                    v.status = STATUS_ILL_ARG;
                end
            end
            else
            begin
                for (int i = 0; i < count; i++)
                begin
                    if (!found && ((r.received_word ^ entry_ident[i]) & entry_mask[i]) == '0)
                    begin
                        found         = 1'b1;
                        v.matched     = 1'b1;
                        v.match_index = MIDX_W'(i);
                        v.dispatch    = entry_valid[i];
                    end
                end
            end
            return v;
        endfunction

        function void note_request(filter_req_t r);
            pending_verdicts.push_back(predict_verdict(r));
        endfunction

        function void check_verdict(filter_verdict_t got);
            filter_verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                $error("result arrived with no request pending");
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.status !== want.status)
            begin
                mismatches++;
                $error("status: expected %0d, got %0d", want.status, got.status);
            end
            if (got.matched !== want.matched)
            begin
                mismatches++;
                $error("matched: expected %0d, got %0d", want.matched, got.matched);
            end
            if (got.match_index !== want.match_index)
            begin
                mismatches++;
                $error("match_index: expected %0d, got %0d", want.match_index, got.match_index);
            end
            if (got.dispatch !== want.dispatch)
            begin
                mismatches++;
                $error("dispatch: expected %0d, got %0d", want.dispatch, got.dispatch);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    logic                 func;
    logic [4:0]           entry_index;
    logic [ID_W-1:0]      filter_id;
    logic [ID_W-1:0]      filter_mask;
    logic                 rtr_flag;
    logic [WORD_W-1:0]    received_word;
    logic                 out_valid;
    logic                 out_stall;
    logic                 status;
    logic                 matched;
    logic [MIDX_W-1:0]    match_index;
    logic                 dispatch;

    filter_bank_scoreboard sb;
    bit                    no_idle;
    bit                    long_hold_req;

    can_rx_acceptance_filter_bank_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .entry_index   (entry_index),
        .filter_id     (filter_id),
        .filter_mask   (filter_mask),
        .rtr_flag      (rtr_flag),
        .received_word (received_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .matched       (matched),
        .match_index   (match_index),
        .dispatch      (dispatch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned draw_gap();
        if (no_idle || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic filter_req_t write_req(int unsigned idx, int unsigned id,
                                              int unsigned mask, bit rtr);
        filter_req_t r;
        r = '{FUNC_WRITE, 5'(idx), ID_W'(id), ID_W'(mask), rtr, '0};
        return r;
    endfunction

    function automatic filter_req_t lookup_req(int unsigned word);
        filter_req_t r;
        r = '{FUNC_LOOKUP, '0, '0, '0, 1'b0, WORD_W'(word)};
        return r;
    endfunction

    function automatic filter_req_t random_request();
        filter_req_t r;
        int unsigned count;
        int unsigned pick;
        int unsigned sel;
        count           = sb.effective_count();
        pick            = $urandom_range(0, 99);
        r.entry_index   = 5'($urandom);
        r.filter_id     = ID_W'($urandom);
        r.filter_mask   = ID_W'($urandom);
        r.rtr_flag      = 1'($urandom);
        r.received_word = WORD_W'($urandom);
        if (pick < 40)
        begin
            r.func = FUNC_WRITE;
            if (count > 0 && $urandom_range(0, 4) != 0)
                r.entry_index = 5'($urandom_range(0, count - 1));
            case ($urandom_range(0, 3))
                0: r.filter_mask = '0;
                1: r.filter_mask = '1;
                default: ;
            endcase
        end
        else
        begin
            r.func = FUNC_LOOKUP;
            if (pick < 75 && count > 0)
            begin
                sel = $urandom_range(0, count - 1);
                r.received_word = sb.entry_ident[sel]
                                  ^ (WORD_W'($urandom) & ~sb.entry_mask[sel]);
            end
            else if (pick < 80)
            begin
                r.received_word = '0;
            end
        end
        return r;
    endfunction

    task automatic send_request(filter_req_t r, int unsigned gap);
        in_valid      <= 1'b1;
        func          <= r.func;
        entry_index   <= r.entry_index;
        filter_id     <= r.filter_id;
        filter_mask   <= r.filter_mask;
        rtr_flag      <= r.rtr_flag;
        received_word <= r.received_word;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_request(r);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        if (in_valid !== 1'b0)
            in_valid <= 1'b0;
        while (sb.pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_active_entries(int unsigned value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ACTIVE_ENTRIES_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sb.set_active_entries(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== PDATA_W'(value))
        begin
            sb.mismatches++;
            $error("active_entries: expected %0d, got %0d", value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_verdict('{status, matched, match_index, dispatch});
    end

    initial
    begin : result_sink
        int unsigned hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                hold          = 300;
                long_hold_req = 1'b0;
            end
            else
            begin
                hold = draw_gap();
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    initial
    begin : stimulus
        int unsigned phase_active [8];
        int unsigned phase_items [8];
        sb            = new();
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        func          = FUNC_WRITE;
        entry_index   = '0;
        filter_id     = '0;
        filter_mask   = '0;
        rtr_flag      = 1'b0;
        received_word = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(lookup_req(16'h0000), draw_gap());
        send_request(lookup_req(16'hFFFF), draw_gap());
        send_request(write_req(0, 11'h7FF, 11'h7FF, 1'b1), draw_gap());
        send_request(lookup_req(16'hFFFE), draw_gap());
        send_request(lookup_req(16'h1FFC), draw_gap());
        send_request(lookup_req(16'h0000), draw_gap());
        send_request(write_req(31, 11'h000, 11'h000, 1'b0), draw_gap());
        send_request(lookup_req(16'h1234), draw_gap());
        send_request(write_req(5, 11'h555, 11'h000, 1'b1), draw_gap());
        send_request(lookup_req(16'hABCF), draw_gap());
        send_request(write_req(17, 11'h2AA, 11'h7F0, 1'b0), draw_gap());
        send_request(lookup_req({3'b111, 11'h2A5, 2'b01}), draw_gap());

        program_active_entries(0);
        send_request(write_req(0, 11'h123, 11'h7FF, 1'b0), draw_gap());
        send_request(lookup_req(16'h0000), draw_gap());

        program_active_entries(1);
        send_request(write_req(1, 11'h7FF, 11'h7FF, 1'b1), draw_gap());
        send_request(write_req(0, 11'h0F0, 11'h7FF, 1'b0), draw_gap());
        send_request(lookup_req({3'b000, 11'h0F0, 2'b00}), draw_gap());
        send_request(lookup_req(16'hFFFE), draw_gap());

        program_active_entries(63);
        send_request(write_req(31, 11'h7FF, 11'h7FF, 1'b1), draw_gap());
        send_request(lookup_req(16'hFFFF), draw_gap());
        send_request(lookup_req(16'h0001), draw_gap());

        phase_active = '{32, 1, $urandom_range(2, 31), 63, 0, $urandom_range(0, 32), 32,
                         $urandom_range(33, 63)};
        phase_items  = '{110, 80, 110, 110, 30, 110, 130, 110};
        for (int p = 0; p < 8; p++)
        begin
            program_active_entries(phase_active[p]);
            no_idle = (p == 2);
            for (int k = 0; k < phase_items[p]; k++)
            begin
                if (p == 3 && k == 20)
                begin
                    long_hold_req = 1'b1;
                    for (int j = 0; j < 12; j++)
                        send_request(random_request(), 0);
                end
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
                send_request(random_request(), draw_gap());
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== can_rx_acceptance_filter_bank_top.f =====
src/canaf_pkg.sv
src/canaf_ram.sv
src/canaf_ctrl.sv
src/canaf_dp.sv
src/can_rx_acceptance_filter_bank_top.sv
dv/tb_can_rx_acceptance_filter_bank_top.sv
